@@ rtl/velocity_slew_and_odometry_top_defines.svh @@
// Assertion macros for the velocity slew and odometry block.
// Taken in by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef VELOCITY_SLEW_AND_ODOMETRY_TOP_DEFINES_SVH
`define VELOCITY_SLEW_AND_ODOMETRY_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define VSO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vso check failed");

// Consequent must hold in the cycle after the antecedent
`define VSO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vso check failed");

`endif

@@ rtl/vso_pkg.sv @@
// Shared types, constants and helper functions for the velocity slew and odometry block.
// No dependencies; used by the controller, the datapath and the top level.
package vso_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SineAw = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [32:0] InvPiQ32 = 33'd1367130551;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  localparam logic [14:0] LimitLinearRst  = 15'd6554;
  localparam logic [14:0] LimitAngularRst = 15'd13107;
  localparam logic [14:0] StepLinearRst   = 15'd197;
  localparam logic [14:0] StepAngularRst  = 15'd393;

  localparam logic [1:0] RegLimitLinear  = 2'd0;
  localparam logic [1:0] RegLimitAngular = 2'd1;
  localparam logic [1:0] RegStepLinear   = 2'd2;
  localparam logic [1:0] RegStepAngular  = 2'd3;

  localparam logic CmdSet  = 1'b0;
  localparam logic CmdTick = 1'b1;

  // Datapath step selected by the controller each cycle
  typedef enum logic [3:0] {
    StepNone,
    StepLookup,
    StepVxCos,
    StepVySin,
    StepVxSin,
    StepVyCos,
    StepRxDt,
    StepRyDt,
    StepWzDt,
    StepInvPi,
    StepHead
  } step_e;

  typedef struct packed {
    logic  accept;
    logic  load_out;
    step_e step;
  } vso_cmd_t;

  typedef logic [14:0] sine_rom_t [SINE_TABLE_DEPTH + 1];

  // Divisor of the k-th series term: (2k+2)(2k+3)
  function automatic longint unsigned series_div(input int k);
    longint unsigned d;
    d = 64'd1;
    case (k)
      0: d = 64'd6;
      1: d = 64'd20;
      2: d = 64'd42;
      3: d = 64'd72;
      4: d = 64'd110;
      5: d = 64'd156;
      6: d = 64'd210;
      7: d = 64'd272;
      8: d = 64'd342;
      9: d = 64'd420;
      default: d = 64'd1;
    endcase
    return d;
  endfunction

  // Unsigned quotient by shift and subtract, used only while building the table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build the quarter-wave sine table with the integer Taylor series
  function automatic sine_rom_t build_rom();
    sine_rom_t       rom;
    longint unsigned x, x2, term, pos, neg, s, v;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = udiv64(HalfPiQ30 * longint'(i), 64'(SINE_TABLE_DEPTH));
      x2   = (x * x) >> 30;
      term = x;
      pos  = 64'd0;
      neg  = 64'd0;
      for (int k = 0; k < 10; k++) begin
        if (k[0]) neg = neg + term;
        else pos = pos + term;
        term = udiv64((term * x2) >> 30, series_div(k));
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      rom[i] = (v > 64'd32767) ? 15'd32767 : v[14:0];
    end
    return rom;
  endfunction

  // Table address for an angle, with the odd quadrants mirrored
  function automatic logic [SineAw-1:0] sine_addr(input logic [31:0] angle);
    logic [30+SineAw-1:0] t;
    logic [SineAw-1:0]    idx;
    t   = {{SineAw{1'b0}}, angle[29:0]} * (30 + SineAw)'(SINE_TABLE_DEPTH);
    idx = t[30+SineAw-1:30];
    if (idx > SineAw'(SINE_TABLE_DEPTH - 1)) idx = SineAw'(SINE_TABLE_DEPTH - 1);
    return angle[30] ? SineAw'(SINE_TABLE_DEPTH) - idx : idx;
  endfunction

  // Symmetric clamp of a Q1.15 value to +/-lim
  function automatic logic [15:0] clamp_sym(input logic [15:0] v, input logic [14:0] lim);
    logic signed [16:0] vs, ls;
    vs = {v[15], v};
    ls = {2'b00, lim};
    if (vs > ls) return ls[15:0];
    if (vs < -ls) return 16'(-ls);
    return v;
  endfunction

  // Move cur toward goal by at most step, never past it
  function automatic logic [15:0] slew(input logic [15:0] cur, input logic [15:0] goal,
                                       input logic [14:0] step);
    logic signed [17:0] c, g, s, r;
    c = {{2{cur[15]}}, cur};
    g = {{2{goal[15]}}, goal};
    s = {3'b000, step};
    r = c;
    if (c < g) begin
      r = c + s;
      if (r > g) r = g;
    end else if (c > g) begin
      r = c - s;
      if (r < g) r = g;
    end
    return r[15:0];
  endfunction

endpackage

@@ rtl/vso_ctrl.sv @@
// Controller state machine for the velocity slew and odometry block.
// Depends on vso_pkg for the command struct and step codes.
module vso_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_command_i,
  input  logic              in_enc_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output vso_pkg::vso_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    SIdle, SLookup, SVxCos, SVySin, SVxSin, SVyCos,
    SRxDt, SRyDt, SWzDt, SInvPi, SHead, SFinish
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept, load_out;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;
  assign accept      = in_ready_o && in_valid_i;
  assign load_out    = (state_q == SFinish) && (!out_valid_q || out_ready_i);

  // Drive the datapath step for the current state
  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.load_out = load_out;
    case (state_q)
      SLookup: cmd_o.step = vso_pkg::StepLookup;
      SVxCos:  cmd_o.step = vso_pkg::StepVxCos;
      SVySin:  cmd_o.step = vso_pkg::StepVySin;
      SVxSin:  cmd_o.step = vso_pkg::StepVxSin;
      SVyCos:  cmd_o.step = vso_pkg::StepVyCos;
      SRxDt:   cmd_o.step = vso_pkg::StepRxDt;
      SRyDt:   cmd_o.step = vso_pkg::StepRyDt;
      SWzDt:   cmd_o.step = vso_pkg::StepWzDt;
      SInvPi:  cmd_o.step = vso_pkg::StepInvPi;
      SHead:   cmd_o.step = vso_pkg::StepHead;
      default: cmd_o.step = vso_pkg::StepNone;
    endcase
  end

  // Sequence one transaction and hold the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            if (in_command_i == vso_pkg::CmdTick && in_enc_valid_i) state_q <= SLookup;
            else state_q <= SFinish;
          end
        end
        SLookup: state_q <= SVxCos;
        SVxCos:  state_q <= SVySin;
        SVySin:  state_q <= SVxSin;
        SVxSin:  state_q <= SVyCos;
        SVyCos:  state_q <= SRxDt;
        SRxDt:   state_q <= SRyDt;
        SRyDt:   state_q <= SWzDt;
        SWzDt:   state_q <= SInvPi;
        SInvPi:  state_q <= SHead;
        SHead:   state_q <= SFinish;
        SFinish: begin
          if (load_out) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

@@ rtl/vso_datapath.sv @@
// Datapath: configuration registers, slew and clamp logic, sine table,
// shared multiplier and pose integrators. Depends on vso_pkg.
module vso_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vso_pkg::vso_cmd_t cmd_i,
  // configuration write and read
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  output logic [31:0]       cfg_rdata_o,
  // input transaction
  input  logic              command_i,
  input  logic              enc_valid_i,
  input  logic [15:0]       target_vx_i,
  input  logic [15:0]       target_vy_i,
  input  logic [15:0]       target_wz_i,
  input  logic [15:0]       meas_vx_i,
  input  logic [15:0]       meas_vy_i,
  input  logic [15:0]       meas_wz_i,
  input  logic [15:0]       dt_i,
  // result transaction
  output logic [15:0]       drive_vx_o,
  output logic [15:0]       drive_vy_o,
  output logic [15:0]       drive_wz_o,
  output logic [31:0]       pose_x_o,
  output logic [31:0]       pose_y_o,
  output logic [31:0]       heading_o,
  output logic              pose_fresh_o,
  output logic [15:0]       miss_count_o
);

  localparam vso_pkg::sine_rom_t SineRom = vso_pkg::build_rom();

  logic [14:0] lim_lin_q, lim_ang_q, step_lin_q, step_ang_q;
  logic [15:0] goal_q [3];
  logic [15:0] drive_q [3];
  logic [31:0] pos_x_q, pos_y_q, head_q;
  logic [15:0] miss_q;
  logic        fresh_q;
  logic [15:0] mvx_q, mvy_q, mwz_q, dt_q;
  logic signed [15:0] sin_q, cos_q;
  logic signed [33:0] rx_q, ry_q;
  logic signed [66:0] prod_q;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic [31:0]        cos_angle;
  logic [vso_pkg::SineAw-1:0] sin_addr, cos_addr;
  logic [14:0]        sin_mag, cos_mag;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_lin_q  <= vso_pkg::LimitLinearRst;
      lim_ang_q  <= vso_pkg::LimitAngularRst;
      step_lin_q <= vso_pkg::StepLinearRst;
      step_ang_q <= vso_pkg::StepAngularRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vso_pkg::RegLimitLinear:  lim_lin_q  <= cfg_wdata_i[14:0];
        vso_pkg::RegLimitAngular: lim_ang_q  <= cfg_wdata_i[14:0];
        vso_pkg::RegStepLinear:   step_lin_q <= cfg_wdata_i[14:0];
        vso_pkg::RegStepAngular:  step_ang_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx_i)
      vso_pkg::RegLimitLinear:  cfg_rdata_o = {17'd0, lim_lin_q};
      vso_pkg::RegLimitAngular: cfg_rdata_o = {17'd0, lim_ang_q};
      vso_pkg::RegStepLinear:   cfg_rdata_o = {17'd0, step_lin_q};
      vso_pkg::RegStepAngular:  cfg_rdata_o = {17'd0, step_ang_q};
      default:                  cfg_rdata_o = 32'd0;
    endcase
  end

  // Table addresses for sine and cosine of the current heading
  assign cos_angle = {head_q[31:30] + 2'd1, head_q[29:0]};
  assign sin_addr  = vso_pkg::sine_addr(head_q);
  assign cos_addr  = vso_pkg::sine_addr(cos_angle);
  assign sin_mag   = SineRom[sin_addr];
  assign cos_mag   = SineRom[cos_addr];

  // Select the operands of the shared multiplier
  always_comb begin
    case (cmd_i.step)
      vso_pkg::StepVxCos: begin
        mul_a = {{18{mvx_q[15]}}, mvx_q};
        mul_b = {{17{cos_q[15]}}, cos_q};
      end
      vso_pkg::StepVySin: begin
        mul_a = {{18{mvy_q[15]}}, mvy_q};
        mul_b = {{17{sin_q[15]}}, sin_q};
      end
      vso_pkg::StepVxSin: begin
        mul_a = {{18{mvx_q[15]}}, mvx_q};
        mul_b = {{17{sin_q[15]}}, sin_q};
      end
      vso_pkg::StepVyCos: begin
        mul_a = {{18{mvy_q[15]}}, mvy_q};
        mul_b = {{17{cos_q[15]}}, cos_q};
      end
      vso_pkg::StepRxDt: begin
        mul_a = rx_q;
        mul_b = {17'd0, dt_q};
      end
      vso_pkg::StepRyDt: begin
        mul_a = ry_q;
        mul_b = {17'd0, dt_q};
      end
      vso_pkg::StepWzDt: begin
        mul_a = {{18{mwz_q[15]}}, mwz_q};
        mul_b = {17'd0, dt_q};
      end
      vso_pkg::StepInvPi: begin
        mul_a = prod_q[33:0];
        mul_b = vso_pkg::InvPiQ32;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register the product of every step
  always_ff @(posedge clk_i) begin
    prod_q <= 67'(mul_a * mul_b);
  end

  // Latch measurements, read the table and build the rotated velocities
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mvx_q <= meas_vx_i;
      mvy_q <= meas_vy_i;
      mwz_q <= meas_wz_i;
      dt_q  <= dt_i;
    end
    case (cmd_i.step)
      vso_pkg::StepLookup: begin
        sin_q <= head_q[31] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
        cos_q <= cos_angle[31] ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});
      end
      vso_pkg::StepVySin: rx_q <= prod_q[33:0];
      vso_pkg::StepVxSin: rx_q <= rx_q - prod_q[33:0];
      vso_pkg::StepVyCos: ry_q <= prod_q[33:0];
      vso_pkg::StepRxDt:  ry_q <= ry_q + prod_q[33:0];
      default: ;
    endcase
  end

  // Goals, drive velocities, pose and miss counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        goal_q[i]  <= '0;
        drive_q[i] <= '0;
      end
      pos_x_q <= '0;
      pos_y_q <= '0;
      head_q  <= '0;
      miss_q  <= '0;
      fresh_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        fresh_q <= 1'b0;
        if (command_i == vso_pkg::CmdSet) begin
          goal_q[0] <= vso_pkg::clamp_sym(target_vx_i, lim_lin_q);
          goal_q[1] <= vso_pkg::clamp_sym(target_vy_i, lim_lin_q);
          goal_q[2] <= vso_pkg::clamp_sym(target_wz_i, lim_ang_q);
        end else begin
          drive_q[0] <= vso_pkg::slew(drive_q[0], goal_q[0], step_lin_q);
          drive_q[1] <= vso_pkg::slew(drive_q[1], goal_q[1], step_lin_q);
          drive_q[2] <= vso_pkg::slew(drive_q[2], goal_q[2], step_ang_q);
          if (enc_valid_i) fresh_q <= 1'b1;
          else if (miss_q != 16'hFFFF) miss_q <= miss_q + 16'd1;
        end
      end
      case (cmd_i.step)
        vso_pkg::StepRyDt: pos_x_q <= pos_x_q + prod_q[61:30];
        vso_pkg::StepWzDt: pos_y_q <= pos_y_q + prod_q[61:30];
        vso_pkg::StepHead: head_q  <= head_q + prod_q[63:32];
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      drive_vx_o   <= drive_q[0];
      drive_vy_o   <= drive_q[1];
      drive_wz_o   <= drive_q[2];
      pose_x_o     <= pos_x_q;
      pose_y_o     <= pos_y_q;
      heading_o    <= head_q;
      pose_fresh_o <= fresh_q;
      miss_count_o <= miss_q;
    end
  end

endmodule

@@ rtl/velocity_slew_and_odometry_top.sv @@
// Top level of the velocity slew and odometry block.
// Depends on vso_pkg, vso_ctrl, vso_datapath and the assertion macro header.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata 112 b, tuser 2 b
//  m_axis    out        tvalid/tready          tdata 160 b, tuser 1 b
//  apb       in         psel/penable/pready    paddr 4 b, pwdata/prdata 32 b
//
// A tick with encoder data runs ten steps through the table read and the single
// shared multiplier; a set item or a tick without encoder data skips them. Reset
// is asynchronous and restores all state but the working and result registers.
// A result waits in the output register while the next item is accepted; a full
// output register stalls the finishing item.
`include "velocity_slew_and_odometry_top_defines.svh"

module velocity_slew_and_odometry_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] target_vx, [31:16] target_vy, [47:32] target_wz, [63:48] meas_vx,
  // [79:64] meas_vy, [95:80] meas_wz, [111:96] dt
  input  logic [111:0] s_axis_tdata,
  // [0] command, [1] enc_valid
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] drive_vx, [31:16] drive_vy, [47:32] drive_wz, [79:48] pose_x,
  // [111:80] pose_y, [143:112] heading, [159:144] miss_count
  output logic [159:0] m_axis_tdata,
  // [0] pose_fresh
  output logic [0:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  vso_pkg::vso_cmd_t cmd;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  vso_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_command_i   (s_axis_tuser[0]),
    .in_enc_valid_i (s_axis_tuser[1]),
    .out_ready_i    (m_axis_tready),
    .in_ready_o     (s_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .cmd_o          (cmd)
  );

  vso_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (paddr[3:2]),
    .cfg_wdata_i  (pwdata),
    .cfg_rdata_o  (prdata),
    .command_i    (s_axis_tuser[0]),
    .enc_valid_i  (s_axis_tuser[1]),
    .target_vx_i  (s_axis_tdata[15:0]),
    .target_vy_i  (s_axis_tdata[31:16]),
    .target_wz_i  (s_axis_tdata[47:32]),
    .meas_vx_i    (s_axis_tdata[63:48]),
    .meas_vy_i    (s_axis_tdata[79:64]),
    .meas_wz_i    (s_axis_tdata[95:80]),
    .dt_i         (s_axis_tdata[111:96]),
    .drive_vx_o   (m_axis_tdata[15:0]),
    .drive_vy_o   (m_axis_tdata[31:16]),
    .drive_wz_o   (m_axis_tdata[47:32]),
    .pose_x_o     (m_axis_tdata[79:48]),
    .pose_y_o     (m_axis_tdata[111:80]),
    .heading_o    (m_axis_tdata[143:112]),
    .pose_fresh_o (m_axis_tuser[0]),
    .miss_count_o (m_axis_tdata[159:144])
  );

  // The input side is busy in the cycle after a transaction is accepted
  `VSO_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A fresh result is only produced as the controller returns to idle
  `VSO_ASSERT_SAME(a_result_frees_input, $rose(m_axis_tvalid), s_axis_tready)

endmodule
